/* sv/positional_list_insert_remove_defines.svh */
// Assertion helpers included by the top-level RTL file.
`ifndef POSITIONAL_LIST_INSERT_REMOVE_DEFINES_SVH
`define POSITIONAL_LIST_INSERT_REMOVE_DEFINES_SVH

`ifndef ASSERT_OFF
// prop must hold on every clock edge outside reset
`define PLIR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// ante in one cycle implies cons in the next
`define PLIR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PLIR_ASSERT(lbl, prop, msg)
`define PLIR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* sv/plir_pkg.sv */
package plir_pkg;

  localparam int unsigned DEPTH      = 64;
  localparam int unsigned DATA_WIDTH = 32;

  // index of one cell, and an entry count that can reach DEPTH
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam int unsigned OP_W    = 3;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CNT_W   = 7;

  // common width for position vs count compares
  localparam int unsigned KW = (CW > POS_W) ? CW : POS_W;

  // removal tap tree: cells per first-level group
  localparam int unsigned GRP  = 8;
  localparam int unsigned NGRP = (DEPTH + GRP - 1) / GRP;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_POS  = 3'd2,
    OP_REM_HEAD = 3'd3,
    OP_REM_TAIL = 3'd4,
    OP_REM_POS  = 3'd5
  } plir_op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } plir_status_e;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] value;
  } plir_req_t;

  typedef struct packed {
    plir_status_e       status;
    logic [VALUE_W-1:0] removed_value;
    logic [CNT_W-1:0]   count;
  } plir_rsp_t;

  // broadcast to every cell in the apply cycle
  typedef struct packed {
    logic                  ins;
    logic                  rem;
    logic [IW-1:0]         at;
    logic [DATA_WIDTH-1:0] val;
  } plir_ctl_t;

endpackage

/* sv/plir_cell.sv */
module plir_cell (
  input  logic                            clk_i,
  input  logic [plir_pkg::IW-1:0]         idx_i,
  input  plir_pkg::plir_ctl_t             ctl_i,
  input  logic [plir_pkg::DATA_WIDTH-1:0] below_i,
  input  logic [plir_pkg::DATA_WIDTH-1:0] above_i,
  output logic [plir_pkg::DATA_WIDTH-1:0] entry_o,
  output logic [plir_pkg::DATA_WIDTH-1:0] tap_o
);
  import plir_pkg::*;

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic [DATA_WIDTH-1:0] tap_q, tap_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.ins) begin
      if (idx_i > ctl_i.at) begin
        entry_d = below_i;
      end else if (idx_i == ctl_i.at) begin
        entry_d = ctl_i.val;
      end
    end else if (ctl_i.rem && (idx_i >= ctl_i.at)) begin
      entry_d = above_i;
    end
  end

  // only the cell being removed drives a nonzero tap
  assign tap_d = (ctl_i.rem && (idx_i == ctl_i.at)) ? entry_q : '0;

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    tap_q   <= tap_d;
  end

  assign entry_o = entry_q;
  assign tap_o   = tap_q;

endmodule

/* sv/plir_tap_tree.sv */
module plir_tap_tree (
  input  logic                            clk_i,
  input  logic [plir_pkg::DATA_WIDTH-1:0] taps_i [plir_pkg::DEPTH],
  output logic [plir_pkg::DATA_WIDTH-1:0] sum_o
);
  import plir_pkg::*;

  logic [DATA_WIDTH-1:0] grp_q [NGRP];
  logic [DATA_WIDTH-1:0] grp_d [NGRP];
  logic [DATA_WIDTH-1:0] sum_q, sum_d;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
      for (int k = 0; k < GRP; k++) begin
        if (g * GRP + k < DEPTH) begin
          grp_d[g] = grp_d[g] | taps_i[g * GRP + k];
        end
      end
    end
  end

  always_comb begin
    sum_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum_d = sum_d | grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

/* sv/positional_list_insert_remove.sv */
// A result strobes on done_o once the operation has passed the apply, gather
// and sum phases, set by the cell tap register and the two registered levels
// of the removal tap tree. A new operation is taken only while busy is low,
// which it is in the last cycle of an operation.
// Reset (rst_ni low, async) clears the entry count and control; entry cells
// are not cleared. The receiver cannot stall: each result is shown one cycle.
`include "positional_list_insert_remove_defines.svh"

module positional_list_insert_remove (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  input  plir_pkg::plir_req_t  req_i,
  output logic                 busy,
  output logic                 done_o,
  output plir_pkg::plir_rsp_t  rsp_o
);
  import plir_pkg::*;

  typedef enum logic [1:0] {
    PH_APPLY,
    PH_GATHER,
    PH_SUM
  } ph_e;

  ph_e          ph_q;
  logic         run_q;
  logic         done_q;
  plir_req_t    cmd_q;
  logic [CW-1:0] cnt_q, cnt_d;
  plir_status_e stat_q, stat_d;
  plir_ctl_t    ctl;
  logic         ins_ok, rem_ok;
  logic [IW-1:0] at;
  logic         apply;
  logic         accept;

  logic [KW-1:0] posx, cntx;
  logic          full, empty;

  logic [DATA_WIDTH-1:0] entry_w [DEPTH];
  logic [DATA_WIDTH-1:0] tap_w   [DEPTH];
  logic [DATA_WIDTH-1:0] removed;

  assign busy   = run_q && (ph_q != PH_SUM);
  assign accept = start && !busy;
  assign apply  = run_q && (ph_q == PH_APPLY);

  assign posx  = KW'(cmd_q.position);
  assign cntx  = KW'(cnt_q);
  assign full  = (cnt_q == CW'(DEPTH));
  assign empty = (cnt_q == '0);

  always_comb begin
    stat_d = ST_OK;
    ins_ok = 1'b0;
    rem_ok = 1'b0;
    at     = '0;
    unique case (plir_op_e'(cmd_q.operation))
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
        if (full) begin
          stat_d = ST_FULL;
        end else if (plir_op_e'(cmd_q.operation) == OP_INS_HEAD) begin
          ins_ok = 1'b1;
        end else if (plir_op_e'(cmd_q.operation) == OP_INS_TAIL) begin
          ins_ok = 1'b1;
          at     = IW'(cnt_q);
        end else if (posx > cntx) begin
          stat_d = ST_BADPOS;
        end else begin
          ins_ok = 1'b1;
          at     = IW'(posx);
        end
      end
      OP_REM_HEAD, OP_REM_TAIL, OP_REM_POS: begin
        if (empty) begin
          stat_d = ST_EMPTY;
        end else if (plir_op_e'(cmd_q.operation) == OP_REM_HEAD) begin
          rem_ok = 1'b1;
        end else if (plir_op_e'(cmd_q.operation) == OP_REM_TAIL) begin
          rem_ok = 1'b1;
          at     = IW'(cnt_q - 1'b1);
        end else if (posx >= cntx) begin
          stat_d = ST_BADPOS;
        end else begin
          rem_ok = 1'b1;
          at     = IW'(posx);
        end
      end
      default: begin
        // unused codes leave the list alone
      end
    endcase
  end

  always_comb begin
    cnt_d = cnt_q;
    if (apply && ins_ok) begin
      cnt_d = cnt_q + 1'b1;
    end else if (apply && rem_ok) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  assign ctl.ins = apply && ins_ok;
  assign ctl.rem = apply && rem_ok;
  assign ctl.at  = at;
  assign ctl.val = cmd_q.value[DATA_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_APPLY;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      stat_q <= ST_OK;
    end else begin
      done_q <= 1'b0;
      cnt_q  <= cnt_d;
      unique case (ph_q)
        PH_APPLY: begin
          if (run_q) begin
            stat_q <= stat_d;
            ph_q   <= PH_GATHER;
          end else if (accept) begin
            run_q <= 1'b1;
          end
        end
        PH_GATHER: begin
          ph_q <= PH_SUM;
        end
        PH_SUM: begin
          done_q <= 1'b1;
          ph_q   <= PH_APPLY;
          run_q  <= accept;
        end
        default: begin
          ph_q <= PH_APPLY;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= req_i;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] below, above;
    if (i == 0) begin : g_first
      assign below = '0;
    end else begin : g_mid_lo
      assign below = entry_w[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = '0;
    end else begin : g_mid_hi
      assign above = entry_w[i+1];
    end
    plir_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IW'(i)),
      .ctl_i   (ctl),
      .below_i (below),
      .above_i (above),
      .entry_o (entry_w[i]),
      .tap_o   (tap_w[i])
    );
  end

  plir_tap_tree u_tree (
    .clk_i  (clk_i),
    .taps_i (tap_w),
    .sum_o  (removed)
  );

  assign done_o              = done_q;
  assign rsp_o.status        = stat_q;
  assign rsp_o.removed_value = VALUE_W'(removed);
  assign rsp_o.count         = CNT_W'(cnt_q);

  `PLIR_ASSERT_NEXT(a_done_after_sum, run_q && (ph_q == PH_SUM), done_q,
                    "result strobe missing after tap sum")
  `PLIR_ASSERT_NEXT(a_ins_counts_up, apply && ins_ok, cnt_q == $past(cnt_q) + 1'b1,
                    "successful insert did not bump count")
  `PLIR_ASSERT_NEXT(a_err_keeps_count, apply && (stat_d != ST_OK), $stable(cnt_q),
                    "error status changed the count")
  `PLIR_ASSERT(a_removed_only_ok, !(done_q && (removed != '0)) || (stat_q == ST_OK),
               "nonzero removed value on an error result")

endmodule
